>>> design/bcc_pkg.sv
// Shared types, codes and reset values for the button click classifier.
package bcc_pkg;

    // Classifier modes
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_HELD   = 3'd1,
        MODE_WAIT   = 3'd2,
        MODE_SECOND = 3'd3,
        MODE_LONG   = 3'd4
    } mode_t;

    // Gesture completed by one poll
    typedef enum logic [1:0] {
        GEST_NONE   = 2'd0,
        GEST_CLICK  = 2'd1,
        GEST_DOUBLE = 2'd2,
        GEST_LONG   = 2'd3
    } gesture_t;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_WIDTH = 8;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHORT_PRESS = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_PRESS  = 8'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SECOND_WAIT = 8'd2;

    localparam int unsigned LIMIT_WIDTH = 16;
    localparam int unsigned TIME_WIDTH  = 32;
    localparam int unsigned FIELD_COUNT_WIDTH = 16;

    localparam logic [LIMIT_WIDTH-1:0] SHORT_PRESS_RESET = 16'd300;
    localparam logic [LIMIT_WIDTH-1:0] LONG_PRESS_RESET  = 16'd1000;
    localparam logic [LIMIT_WIDTH-1:0] SECOND_WAIT_RESET = 16'd300;

    localparam int unsigned COUNT_WIDTH_DEFAULT = 16;

    // Word widths on the stream ports
    localparam int unsigned IN_DATA_WIDTH  = 40;
    localparam int unsigned OUT_DATA_WIDTH = 56;

    // Threshold registers
    typedef struct packed {
        logic [LIMIT_WIDTH-1:0] short_press;
        logic [LIMIT_WIDTH-1:0] long_press;
        logic [LIMIT_WIDTH-1:0] second_wait;
    } limits_t;

    // Classifier state apart from the counters
    typedef struct packed {
        mode_t                 mode;
        logic [TIME_WIDTH-1:0] press_stamp;
        logic [TIME_WIDTH-1:0] release_stamp;
        logic                  last_level;
    } ctrl_t;

    // Counter increments requested by one poll
    typedef struct packed {
        logic click;
        logic double_click;
        logic long_press;
    } bump_t;

endpackage

>>> design/button_click_classifier.sv
// The result word is registered. Throughput: one poll per cycle when not stalled;
// the classifier state updates in the accepting cycle.
// A new poll enters while the previous result word drains; a stalled result word
// holds off the input. Reset (aresetn low, synchronous): mode idle, stamps, level and
// counters zero, thresholds back to 300, 1000 and 300 ms, no result word pending.
module button_click_classifier
    import bcc_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // Poll input: tdata = pressed[0], time_now[32:1], zero pad
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [IN_DATA_WIDTH-1:0]   s_tdata,
    // Result output: tdata = mode[2:0], gesture[4:3], clicks[20:5],
    // double_clicks[36:21], long_presses[52:37], zero pad
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [OUT_DATA_WIDTH-1:0]  m_tdata,
    // Configuration writes
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [LIMIT_WIDTH-1:0]     cfg_data
);

    limits_t                limits_reg;
    ctrl_t                  ctrl_reg;
    ctrl_t                  ctrl_next;
    logic [COUNT_WIDTH-1:0] click_reg,  click_next;
    logic [COUNT_WIDTH-1:0] double_reg, double_next;
    logic [COUNT_WIDTH-1:0] long_reg,   long_next;
    logic                   out_valid_reg;
    logic [OUT_DATA_WIDTH-1:0] out_data_reg, out_data_next;
    gesture_t               gesture;
    bump_t                  bump;
    logic                   in_fire;
    logic                   in_pressed;
    logic [TIME_WIDTH-1:0]  in_time;

    assign in_pressed = s_tdata[0];
    assign in_time    = s_tdata[TIME_WIDTH:1];

    // Accept a poll whenever the output slot is free or draining
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    bcc_step u_step (
        .ctrl      (ctrl_reg),
        .limits    (limits_reg),
        .pressed   (in_pressed),
        .time_now  (in_time),
        .ctrl_next (ctrl_next),
        .gesture   (gesture),
        .bump      (bump)
    );

    // Advance the counters, wrapping at their width
    assign click_next  = click_reg  + COUNT_WIDTH'(bump.click);
    assign double_next = double_reg + COUNT_WIDTH'(bump.double_click);
    assign long_next   = long_reg   + COUNT_WIDTH'(bump.long_press);

    // Pack the result word
    always_comb begin
        logic [31:0] clk_w;
        logic [31:0] dbl_w;
        logic [31:0] lng_w;
        clk_w = 32'(click_next);
        dbl_w = 32'(double_next);
        lng_w = 32'(long_next);
        out_data_next = '0;
        out_data_next[2:0]   = ctrl_next.mode;
        out_data_next[4:3]   = gesture;
        out_data_next[20:5]  = clk_w[FIELD_COUNT_WIDTH-1:0];
        out_data_next[36:21] = dbl_w[FIELD_COUNT_WIDTH-1:0];
        out_data_next[52:37] = lng_w[FIELD_COUNT_WIDTH-1:0];
    end

    // Hold thresholds; write on a configuration word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limits_reg.short_press <= SHORT_PRESS_RESET;
            limits_reg.long_press  <= LONG_PRESS_RESET;
            limits_reg.second_wait <= SECOND_WAIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_SHORT_PRESS: limits_reg.short_press <= cfg_data;
                REG_LONG_PRESS:  limits_reg.long_press  <= cfg_data;
                REG_SECOND_WAIT: limits_reg.second_wait <= cfg_data;
                default: ;
            endcase
        end
    end

    // Update classifier state and counters on each accepted poll
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg.mode          <= MODE_IDLE;
            ctrl_reg.press_stamp   <= '0;
            ctrl_reg.release_stamp <= '0;
            ctrl_reg.last_level    <= 1'b0;
            click_reg              <= '0;
            double_reg             <= '0;
            long_reg               <= '0;
        end else if (in_fire) begin
            ctrl_reg   <= ctrl_next;
            click_reg  <= click_next;
            double_reg <= double_next;
            long_reg   <= long_next;
        end
    end

    // Output word valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output word payload
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> design/bcc_step.sv
// Next-state logic of the classifier: edge event first, then the tick.
module bcc_step
    import bcc_pkg::*;
(
    input  ctrl_t                  ctrl,
    input  limits_t                limits,
    input  logic                   pressed,
    input  logic [TIME_WIDTH-1:0]  time_now,
    output ctrl_t                  ctrl_next,
    output gesture_t               gesture,
    output bump_t                  bump
);

    ctrl_t                 mid;
    logic [TIME_WIDTH-1:0] held_time;
    logic [TIME_WIDTH-1:0] tick_held_time;
    logic [TIME_WIDTH-1:0] tick_wait_time;

    // Elapsed times, wrapping modulo 2^32
    assign held_time = time_now - ctrl.press_stamp;

    always_comb begin
        mid       = ctrl;
        ctrl_next = ctrl;
        gesture   = GEST_NONE;
        bump      = '0;

        // Handle a press or release when the level changed
        mid.last_level = pressed;
        if (pressed != ctrl.last_level) begin
            case (ctrl.mode)
                MODE_IDLE: begin
                    if (pressed) begin
                        mid.mode        = MODE_HELD;
                        mid.press_stamp = time_now;
                    end
                end
                MODE_HELD: begin
                    if (!pressed) begin
                        mid.release_stamp = time_now;
                        if (held_time < TIME_WIDTH'(limits.short_press)) begin
                            mid.mode = MODE_WAIT;
                        end else begin
                            mid.mode   = MODE_IDLE;
                            bump.click = 1'b1;
                            gesture    = GEST_CLICK;
                        end
                    end
                end
                MODE_WAIT: begin
                    if (pressed) begin
                        mid.mode = MODE_SECOND;
                    end
                end
                MODE_SECOND: begin
                    if (!pressed) begin
                        mid.mode          = MODE_IDLE;
                        bump.double_click = 1'b1;
                        gesture           = GEST_DOUBLE;
                    end
                end
                MODE_LONG: begin
                    if (!pressed) begin
                        mid.mode        = MODE_IDLE;
                        bump.long_press = 1'b1;
                        gesture         = GEST_LONG;
                    end
                end
                default: ;
            endcase
        end

        // Handle the periodic tick at the same time
        tick_held_time = time_now - mid.press_stamp;
        tick_wait_time = time_now - mid.release_stamp;
        ctrl_next = mid;
        case (mid.mode)
            MODE_HELD: begin
                if (tick_held_time > TIME_WIDTH'(limits.long_press)) begin
                    ctrl_next.mode = MODE_LONG;
                end
            end
            MODE_WAIT: begin
                if (tick_wait_time > TIME_WIDTH'(limits.second_wait)) begin
                    ctrl_next.mode = MODE_IDLE;
                    bump.click     = 1'b1;
                    gesture        = GEST_CLICK;
                end
            end
            default: ;
        endcase
    end

endmodule

>>> dv/button_click_classifier_tb.sv
// Self-checking testbench for the button click classifier: gesture polls against a predictor.
module button_click_classifier_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bcc_pkg::*;

    localparam int unsigned IDLE_LIMIT = 2000;
    localparam int unsigned HOLD_OFF_CYCLES = 80;
    // Register indexes that the block does not decode
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_LOW  = 8'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_HIGH = 8'hFF;

    typedef enum {KIND_PRESS, KIND_RELEASE, KIND_TICK} poll_kind_t;

    typedef struct {
        mode_t                        mode;
        gesture_t                     gesture;
        logic [FIELD_COUNT_WIDTH-1:0] clicks;
        logic [FIELD_COUNT_WIDTH-1:0] double_clicks;
        logic [FIELD_COUNT_WIDTH-1:0] long_presses;
    } poll_report_t;

    // Gesture state machine mirror plus the queue of reports it predicts
    class gesture_tracker;
        logic [LIMIT_WIDTH-1:0]       short_limit;
        logic [LIMIT_WIDTH-1:0]       long_limit;
        logic [LIMIT_WIDTH-1:0]       wait_limit;
        mode_t                        mode;
        logic [TIME_WIDTH-1:0]        press_stamp;
        logic [TIME_WIDTH-1:0]        release_stamp;
        logic                         last_level;
        logic [FIELD_COUNT_WIDTH-1:0] clicks;
        logic [FIELD_COUNT_WIDTH-1:0] double_clicks;
        logic [FIELD_COUNT_WIDTH-1:0] long_presses;
        poll_report_t                 expected_reports[$];
        int                           mismatches;

        function new();
            short_limit   = SHORT_PRESS_RESET;
            long_limit    = LONG_PRESS_RESET;
            wait_limit    = SECOND_WAIT_RESET;
            mode          = MODE_IDLE;
            press_stamp   = '0;
            release_stamp = '0;
            last_level    = 1'b0;
            clicks        = '0;
            double_clicks = '0;
            long_presses  = '0;
            mismatches    = 0;
        endfunction

        function void set_limit(logic [CFG_INDEX_WIDTH-1:0] index,
                                logic [LIMIT_WIDTH-1:0] value);
            case (index)
                REG_SHORT_PRESS: short_limit = value;
                REG_LONG_PRESS:  long_limit = value;
                REG_SECOND_WAIT: wait_limit = value;
                default: ;
            endcase
        endfunction

        // Advance the mode for one press, release or tick
        function void apply(poll_kind_t kind, logic [TIME_WIDTH-1:0] now,
                            inout gesture_t gesture);
            logic [TIME_WIDTH-1:0] held;
            logic [TIME_WIDTH-1:0] since_release;
            held = now - press_stamp;
            since_release = now - release_stamp;
            case (mode)
                MODE_IDLE: begin
                    if (kind == KIND_PRESS) begin
                        mode = MODE_HELD;
                        press_stamp = now;
                    end
                end
                MODE_HELD: begin
                    if (kind == KIND_RELEASE) begin
                        release_stamp = now;
                        if (held < TIME_WIDTH'(short_limit)) begin
                            mode = MODE_WAIT;
                        end else begin
                            mode = MODE_IDLE;
                            clicks++;
                            gesture = GEST_CLICK;
                        end
                    end
                    if (kind == KIND_TICK && mode == MODE_HELD && held > TIME_WIDTH'(long_limit))
                        mode = MODE_LONG;
                end
                MODE_WAIT: begin
                    if (kind == KIND_PRESS) begin
                        mode = MODE_SECOND;
                    end else if (kind == KIND_TICK &&
                                 since_release > TIME_WIDTH'(wait_limit)) begin
                        mode = MODE_IDLE;
                        clicks++;
                        gesture = GEST_CLICK;
                    end
                end
                MODE_SECOND: begin
                    if (kind == KIND_RELEASE) begin
                        mode = MODE_IDLE;
                        double_clicks++;
                        gesture = GEST_DOUBLE;
                    end
                end
                MODE_LONG: begin
                    if (kind == KIND_RELEASE) begin
                        mode = MODE_IDLE;
                        long_presses++;
                        gesture = GEST_LONG;
                    end
                end
                default: ;
            endcase
        endfunction

        // Level change first, then the tick at the same time
        function void note_poll(logic level, logic [TIME_WIDTH-1:0] now);
            poll_report_t report;
            gesture_t     gesture;
            gesture = GEST_NONE;
            if (level != last_level) begin
                apply(level ? KIND_PRESS : KIND_RELEASE, now, gesture);
                last_level = level;
            end
            apply(KIND_TICK, now, gesture);
            report.mode          = mode;
            report.gesture       = gesture;
            report.clicks        = clicks;
            report.double_clicks = double_clicks;
            report.long_presses  = long_presses;
            expected_reports.push_back(report);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_report(logic [OUT_DATA_WIDTH-1:0] word);
            poll_report_t want;
            if (expected_reports.size() == 0) begin
                $display("%0t: result word with nothing expected, expected none actual %h",
                         $time, word);
                mismatches++;
                return;
            end
            want = expected_reports.pop_front();
            compare_field("mode", 32'(want.mode), 32'(word[2:0]));
            compare_field("gesture", 32'(want.gesture), 32'(word[4:3]));
            compare_field("clicks", 32'(want.clicks), 32'(word[20:5]));
            compare_field("double_clicks", 32'(want.double_clicks), 32'(word[36:21]));
            compare_field("long_presses", 32'(want.long_presses), 32'(word[52:37]));
        endfunction
    endclass

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [IN_DATA_WIDTH-1:0]   s_tdata;   // pressed, time_now, zero pad
    logic                       m_tvalid;
    logic                       m_tready;
    logic [OUT_DATA_WIDTH-1:0]  m_tdata;   // mode, gesture, clicks, double_clicks, long_presses
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [LIMIT_WIDTH-1:0]     cfg_data;

    gesture_tracker        tracker = new();
    logic [TIME_WIDTH-1:0] now_ms = '0;
    bit                    calm = 1'b0;
    int                    polls_sent = 0;
    int                    reports_seen = 0;
    int                    idle_cycles = 0;

    button_click_classifier dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // Check every accepted result word
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tracker.check_report(m_tdata);
            reports_seen++;
        end
    end

    // Abort when no word moves on any channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: random stalls, one long hold-off to back up the block
    initial begin : result_sink
        bit held_off;
        held_off = 1'b0;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (!held_off && reports_seen >= 200) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                m_tready <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one poll word, with an optional gap ahead of it
    task automatic send_poll(input logic level, input logic [TIME_WIDTH-1:0] stamp);
        if (!calm && $urandom_range(0, 4) == 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end else begin
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(IN_DATA_WIDTH - TIME_WIDTH - 1){1'b0}}, stamp, level};
        do @(posedge aclk); while (!s_tready);
        tracker.note_poll(level, stamp);
        polls_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] index,
                             input logic [LIMIT_WIDTH-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        tracker.set_limit(index, value);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Stop offering and wait until every result word has come back
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (tracker.expected_reports.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Durations clustered on a threshold and its neighbors
    function automatic int unsigned near_limit(int unsigned limit);
        case ($urandom_range(0, 5))
            0: return 0;
            1: return limit - 1;
            2: return limit;
            3: return limit + 1;
            4: return $urandom_range(0, 2 * limit + 2);
            default: return $urandom_range(0, 8);
        endcase
    endfunction

    // Hold one level for a span, polling at its start and up to three times along the way
    task automatic hold_level(input logic level, input int unsigned span);
        logic [TIME_WIDTH-1:0] start;
        int unsigned           steps;
        start = now_ms;
        send_poll(level, now_ms);
        steps = $urandom_range(0, 3);
        repeat (steps) begin
            now_ms += $urandom_range(0, span / steps);
            send_poll(level, now_ms);
        end
        now_ms = start + span;
    endtask

    // One gesture with random timing, or a stray poll
    task automatic random_gesture();
        case ($urandom_range(0, 9))
            0, 1: begin
                now_ms = $urandom();
                send_poll(1'($urandom_range(0, 1)), now_ms);
            end
            2, 3, 4: begin
                hold_level(1'b1, near_limit($urandom_range(0, 1) ? tracker.short_limit
                                                                 : tracker.long_limit));
                hold_level(1'b0, near_limit(tracker.wait_limit));
            end
            5, 6, 7: begin
                hold_level(1'b1, near_limit(tracker.short_limit));
                hold_level(1'b0, near_limit(tracker.wait_limit));
                hold_level(1'b1, near_limit(tracker.short_limit));
                hold_level(1'b0, near_limit(tracker.wait_limit));
            end
            default: begin
                hold_level(1'b1, near_limit(tracker.long_limit));
                hold_level(1'b0, near_limit(tracker.wait_limit));
            end
        endcase
    endtask

    task automatic run_phase(input logic [LIMIT_WIDTH-1:0] short_v,
                             input logic [LIMIT_WIDTH-1:0] long_v,
                             input logic [LIMIT_WIDTH-1:0] wait_v,
                             input int target);
        drain();
        write_reg(REG_SHORT_PRESS, short_v);
        write_reg(REG_LONG_PRESS, long_v);
        write_reg(REG_SECOND_WAIT, wait_v);
        while (polls_sent < target) random_gesture();
    endtask

    // Hand-picked polls at the reset thresholds of 300, 1000 and 300 ms
    task automatic directed_polls();
        // pressed on the very first poll, then held to a long press
        send_poll(1'b1, 32'd0);
        send_poll(1'b1, 32'd1000);
        send_poll(1'b1, 32'd1001);
        send_poll(1'b0, 32'd1010);
        send_poll(1'b0, 32'hFFFF_FFFF);
        // hold of exactly the short limit across the time wrap: click
        send_poll(1'b1, 32'hFFFF_FF00);
        send_poll(1'b0, 32'h0000_002C);
        // short hold, then wait out the second press window
        send_poll(1'b1, 32'd100);
        send_poll(1'b0, 32'd399);
        send_poll(1'b0, 32'd699);
        send_poll(1'b0, 32'd700);
        // double click with a long second hold
        send_poll(1'b1, 32'd800);
        send_poll(1'b0, 32'd850);
        send_poll(1'b1, 32'd900);
        send_poll(1'b1, 32'd5000);
        send_poll(1'b0, 32'd5001);
        // short hold that times out into a click
        send_poll(1'b1, 32'd6000);
        send_poll(1'b0, 32'd6010);
        send_poll(1'b0, 32'd6400);
        now_ms = 32'd6400;
    endtask

    initial begin : stimulus
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // undecoded indexes must leave the thresholds alone
        write_reg(REG_SPARE_LOW, 16'h0000);
        write_reg(REG_SPARE_HIGH, 16'hFFFF);
        directed_polls();

        run_phase(16'h0000, 16'h0000, 16'h0000, 150);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 280);
        run_phase(LIMIT_WIDTH'($urandom_range(1, 400)), LIMIT_WIDTH'($urandom_range(1, 400)),
                  LIMIT_WIDTH'($urandom_range(1, 400)), 420);
        run_phase(LIMIT_WIDTH'($urandom_range(0, 16'hFFFF)),
                  LIMIT_WIDTH'($urandom_range(0, 16'hFFFF)),
                  LIMIT_WIDTH'($urandom_range(0, 16'hFFFF)), 560);
        // closing stretch with no idling on either side
        calm = 1'b1;
        run_phase(LIMIT_WIDTH'($urandom_range(50, 1500)),
                  LIMIT_WIDTH'($urandom_range(50, 1500)),
                  LIMIT_WIDTH'($urandom_range(50, 1500)), 700);
        drain();

        if (tracker.mismatches == 0 && tracker.expected_reports.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> sim.f
design/bcc_pkg.sv
design/bcc_step.sv
design/button_click_classifier.sv
dv/button_click_classifier_tb.sv
